// ----- rtl/core/bitmap_page_allocator_defines.svh -----
// assertion helpers for the page allocator
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPA_ASSERT(label, clk, rst_n, prop, msg)
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/bpa_pkg.sv -----
package bpa_pkg;

  localparam int unsigned NumPagesDef = 65536;
  localparam int unsigned ReservedPagesDef = 3584;
  localparam int unsigned WordBitsDef = 64;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_MARK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_RUN  = 2'd1,
    STATUS_RANGE   = 2'd2,
    STATUS_UNUSED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] page_index;
    logic [16:0] page_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] base_page;
    logic [16:0] free_pages;
    logic [16:0] used_pages;
  } rsp_t;

endpackage

// ----- rtl/core/bpa_if.sv -----
interface bpa_req_if;
  import bpa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/bpa_ram.sv -----
module bpa_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/bitmap_page_allocator.sv -----
// First-fit page allocator with one used bit per page, held as NumPages/WordBits words in
// one single-port-read RAM. After reset a clearing pass writes every map word (reserved
// pages set), one word a cycle, before the first request is taken.
// Every request is handled by a sequencer that walks the map one bit per cycle, pausing
// for each word read and write-back, through a shared bit test/update unit: a read
// fetches a word (S_RD, then S_WAIT) into a register. Allocate scans from page 0 until
// a run is found, then walks the run again to set it. Free and mark walk only their run;
// a request with nothing to walk (no pages, out of range, no function) goes straight to
// the result. The result sits in an output register; the next request is taken once it is delivered.
module bitmap_page_allocator #(
  parameter int unsigned NumPages = bpa_pkg::NumPagesDef,
  parameter int unsigned ReservedPages = bpa_pkg::ReservedPagesDef,
  parameter int unsigned WordBits = bpa_pkg::WordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpa_req_if.sink     req,
  bpa_rsp_if.source   rsp
);
  import bpa_pkg::*;
  `include "bitmap_page_allocator_defines.svh"

  localparam int unsigned MapWords = (NumPages + WordBits - 1) / WordBits;
  localparam int unsigned AW = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned BW = $clog2(WordBits);
  localparam int unsigned PW = $clog2(NumPages + 1) + 1;
  localparam int unsigned Resv = (ReservedPages > NumPages) ? NumPages : ReservedPages;
  localparam logic [PW-1:0] NumP = PW'(NumPages);
  localparam logic [PW-1:0] ResvP = PW'(Resv);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_WAIT  = 8'b0000_1000,
    S_BIT   = 8'b0001_0000,
    S_WB    = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [PW-1:0] page_q, page_d, run_q, run_d, cnt_q, cnt_d, free_q, free_d;
  logic [PW-1:0] end_q, end_d, base_q, base_d;
  logic [1:0] func_q, func_d;
  logic scan_q, scan_d, dirty_q, dirty_d;
  logic [WordBits-1:0] word_q, word_d, rdata;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0] status_q, status_d;
  logic rsp_valid_q, rsp_valid_d;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [WordBits-1:0] wdata, clr_word;
  logic [BW-1:0] bsel;
  logic cur;
  logic [PW-1:0] clr_base;

  assign bsel = page_q[BW-1:0];
  assign cur = word_q[bsel];
  assign clr_base = PW'(clr_q) * PW'(WordBits);

  always_comb begin
    for (int i = 0; i < WordBits; i++) begin
      clr_word[i] = (clr_base + PW'(i)) < ResvP;
    end
  end

  bpa_ram #(.Width(WordBits), .Depth(MapWords)) u_map (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign raddr = AW'(page_q >> BW);
  assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.data.status = status_q;
  assign rsp.data.base_page = base_q[15:0];
  assign rsp.data.free_pages = free_q[16:0];
  assign rsp.data.used_pages = 17'(NumP - free_q);

  always_comb begin
    state_d = state_q; page_d = page_q; run_d = run_q; cnt_d = cnt_q;
    free_d = free_q; end_d = end_q; base_d = base_q; func_d = func_q;
    scan_d = scan_q; dirty_d = dirty_q; word_d = word_q; clr_d = clr_q;
    status_d = status_q; rsp_valid_d = rsp_valid_q;
    we = 1'b0; waddr = AW'(page_q >> BW); wdata = word_q;
    if (rsp.valid && rsp.ready) rsp_valid_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_q; wdata = clr_word;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MapWords - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid && req.ready) begin
          func_d = req.data.func; status_d = STATUS_OK; base_d = '0;
          run_d = '0; dirty_d = 1'b0; cnt_d = PW'(req.data.page_count);
          state_d = S_DONE;
          unique case (req.data.func)
            FUNC_ALLOC: begin
              page_d = '0; scan_d = 1'b1;
              if (req.data.page_count != '0) begin
                if (PW'(req.data.page_count) > NumP) status_d = STATUS_NO_RUN;
                else state_d = S_RD;
              end
            end
            FUNC_FREE: begin
              page_d = PW'(req.data.page_index); scan_d = 1'b0;
              end_d = PW'(req.data.page_index) + PW'(req.data.page_count);
              if (PW'(req.data.page_index) + PW'(req.data.page_count) > NumP)
                status_d = STATUS_RANGE;
              else if (req.data.page_count != '0) state_d = S_RD;
            end
            FUNC_MARK: begin
              page_d = PW'(req.data.page_index); scan_d = 1'b0;
              end_d = PW'(req.data.page_index) + PW'(1);
              if (PW'(req.data.page_index) >= NumP) status_d = STATUS_RANGE;
              else state_d = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: state_d = S_WAIT;
      S_WAIT: begin word_d = rdata; dirty_d = 1'b0; state_d = S_BIT; end
      S_BIT: begin
        page_d = page_q + PW'(1);
        if (scan_q) begin
          if (cur) run_d = '0;
          else begin
            run_d = run_q + PW'(1);
            if (run_q + PW'(1) == cnt_q) begin
              base_d = page_q + PW'(1) - cnt_q;
              page_d = page_q + PW'(1) - cnt_q;
              end_d = page_q + PW'(1);
              scan_d = 1'b0;
              state_d = S_RD;
            end
          end
          if (scan_q && state_d == S_BIT) begin
            if (page_q + PW'(1) >= NumP) begin
              status_d = STATUS_NO_RUN; state_d = S_DONE;
            end else if (&bsel) state_d = S_RD;
          end
        end else begin
          if (func_q == FUNC_FREE) begin
            if (cur) begin word_d[bsel] = 1'b0; free_d = free_q + PW'(1); end
          end else if (!cur) begin
            word_d[bsel] = 1'b1; free_d = free_q - PW'(1);
          end
          dirty_d = 1'b1;
          if (page_q + PW'(1) >= end_q || (&bsel)) state_d = S_WB;
        end
      end
      S_WB: begin
        we = 1'b1; waddr = AW'(page_q - PW'(1) >> BW); wdata = word_q;
        state_d = (page_q >= end_q) ? S_DONE : S_RD;
      end
      S_DONE: begin rsp_valid_d = 1'b1; state_d = S_OUT; end
      S_OUT: if (!rsp_valid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; free_q <= NumP - ResvP;
      rsp_valid_q <= 1'b0; scan_q <= 1'b0; dirty_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; free_q <= free_d;
      rsp_valid_q <= rsp_valid_d; scan_q <= scan_d; dirty_q <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d; run_q <= run_d; cnt_q <= cnt_d; end_q <= end_d;
    base_q <= base_d; func_q <= func_d; word_q <= word_d; status_q <= status_d;
  end

  `BPA_ASSERT(a_free_bound, clk_i, rst_ni, free_q <= NumP, "free count above page total")
  `BPA_ASSERT(a_no_accept_busy, clk_i, rst_ni, !(req.ready && rsp_valid_q), "ready while result held")
  `BPA_ASSERT_NEXT(a_done_valid, clk_i, rst_ni, state_q == S_DONE, rsp_valid_q, "result not raised")
  `BPA_ASSERT_NEXT(a_wb_dirty, clk_i, rst_ni, state_q == S_WB, !scan_q, "write back during scan")
endmodule

// ----- sim/tb_bitmap_page_allocator.sv -----
module tb_bitmap_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int unsigned NPages = NumPagesDef;
  localparam int unsigned NReserved = ReservedPagesDef;
  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned NRandom = 520;

  typedef struct {
    func_e      f;
    int         idx;
    int         cnt;
    bit         lit;
    rsp_t       res;
  } row_t;

  typedef struct {
    int base;
    int cnt;
  } run_t;

  logic clk;
  logic rst_n;

  bpa_req_if req ();
  bpa_rsp_if rsp ();

  bitmap_page_allocator dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req   (req.sink),
    .rsp   (rsp.source)
  );

  bit   page_map [NPages];
  int   free_cnt;
  rsp_t result_q [$];
  run_t held_runs [$];
  int   errors;
  int   cycles;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   n_alloc_ok, n_no_run, n_range, n_sent;
  row_t dir [18];

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, result_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
  endtask

  function automatic void map_reset();
    free_cnt = NPages;
    for (int p = 0; p < NPages; p++) page_map[p] = 1'b0;
    for (int p = 0; p < NReserved && p < NPages; p++) begin
      page_map[p] = 1'b1;
      free_cnt--;
    end
  endfunction

  function automatic void set_page(int p, bit used);
    if (p < NPages && page_map[p] != used) begin
      page_map[p] = used;
      free_cnt += used ? -1 : 1;
    end
  endfunction

  // first-fit allocator behavior on the local copy of the map
  function automatic rsp_t allocate_step(req_t r);
    rsp_t o;
    int run, base, cnt, idx;
    bit found;
    o = '0;
    o.status = STATUS_OK;
    cnt = int'(r.page_count);
    idx = int'(r.page_index);
    run = 0;
    base = 0;
    found = 1'b0;
    case (func_e'(r.func))
      FUNC_ALLOC: begin
        if (cnt > 0) begin
          for (int p = 0; p < NPages; p++) begin
            if (page_map[p]) begin
              run = 0;
            end else begin
              run++;
              if (run == cnt) begin
                base = p + 1 - cnt;
                found = 1'b1;
                break;
              end
            end
          end
          if (found) begin
            for (int p = base; p < base + cnt; p++) set_page(p, 1'b1);
            held_runs.push_back('{base, cnt});
            o.base_page = base[15:0];
          end else begin
            o.status = STATUS_NO_RUN;
          end
        end
      end
      FUNC_FREE: begin
        if (longint'(idx) + cnt > NPages) o.status = STATUS_RANGE;
        else for (int p = idx; p < idx + cnt; p++) set_page(p, 1'b0);
      end
      FUNC_MARK: begin
        if (idx >= NPages) o.status = STATUS_RANGE;
        else set_page(idx, 1'b1);
      end
      default: ;
    endcase
    o.free_pages = free_cnt[16:0];
    o.used_pages = 17'(NPages - free_cnt);
    return o;
  endfunction

  task automatic send(req_t r, bit lit, rsp_t lit_res);
    rsp_t o;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    // beat accepted at this edge
    o = allocate_step(r);
    n_sent++;
    if (o.status == STATUS_NO_RUN) n_no_run++;
    if (o.status == STATUS_RANGE) n_range++;
    if (func_e'(r.func) == FUNC_ALLOC && o.status == STATUS_OK) n_alloc_ok++;
    result_q.push_back(lit ? lit_res : o);
  endtask

  always @(posedge clk) begin
    rsp_t w;
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && rsp.valid && rsp.ready) begin
      if (result_q.size() == 0) begin
        report("unexpected result beat", int'(rsp.data.status), -1);
      end else begin
        w = result_q.pop_front();
        if (rsp.data.status !== w.status)
          report("status", int'(rsp.data.status), int'(w.status));
        if (rsp.data.base_page !== w.base_page)
          report("base_page", int'(rsp.data.base_page), int'(w.base_page));
        if (rsp.data.free_pages !== w.free_pages)
          report("free_pages", int'(rsp.data.free_pages), int'(w.free_pages));
        if (rsp.data.used_pages !== w.used_pages)
          report("used_pages", int'(rsp.data.used_pages), int'(w.used_pages));
      end
    end
  end

  function automatic req_t random_item();
    req_t r;
    int pick, k;
    pick = $urandom_range(99);
    r.page_index = 16'($urandom);
    r.page_count = 17'($urandom_range(1, 16));
    if (pick < 38) begin
      r.func = FUNC_ALLOC;
      if ($urandom_range(9) == 0) r.page_count = 17'($urandom_range(0, 300));
    end else if (pick < 70) begin
      r.func = FUNC_FREE;
      if (held_runs.size() > 0) begin
        // give back a run handed out earlier
        k = $urandom_range(held_runs.size() - 1);
        r.page_index = 16'(held_runs[k].base);
        r.page_count = 17'(held_runs[k].cnt);
        held_runs.delete(k);
      end
    end else if (pick < 82) begin
      r.func = FUNC_MARK;
      r.page_count = 17'($urandom);
    end else if (pick < 94) begin
      // run past the end
      r.func = FUNC_FREE;
      r.page_count = 17'($urandom_range(NPages - int'(r.page_index) + 1, 131071));
    end else begin
      r.func = FUNC_NONE;
      r.page_count = 17'($urandom);
    end
    return r;
  endfunction

  initial begin
    req_t r;
    rsp_t none;
    rst_n = 1'b0;
    req.valid = 1'b0;
    req.data = '0;
    n_sent = 0;
    n_alloc_ok = 0;
    n_no_run = 0;
    n_range = 0;
    send_idle_pct = 15;
    recv_idle_pct = 82;
    none = '0;
    map_reset();

    dir[0]  = '{FUNC_ALLOC, 0, 0, 1'b1, '{STATUS_OK, 16'd0, 17'd61952, 17'd3584}};
    dir[1]  = '{FUNC_ALLOC, 0, 1, 1'b1, '{STATUS_OK, 16'd3584, 17'd61951, 17'd3585}};
    dir[2]  = '{FUNC_MARK, 3585, 0, 1'b0, none};
    dir[3]  = '{FUNC_MARK, 3585, 7, 1'b0, none};
    dir[4]  = '{FUNC_MARK, 65535, 131071, 1'b0, none};
    dir[5]  = '{FUNC_FREE, 65535, 2, 1'b1, '{STATUS_RANGE, 16'd0, 17'd61949, 17'd3587}};
    dir[6]  = '{FUNC_FREE, 1, 65536, 1'b1, '{STATUS_RANGE, 16'd0, 17'd61949, 17'd3587}};
    dir[7]  = '{FUNC_FREE, 0, 0, 1'b1, '{STATUS_OK, 16'd0, 17'd61949, 17'd3587}};
    dir[8]  = '{FUNC_FREE, 3584, 1, 1'b0, none};
    dir[9]  = '{FUNC_FREE, 3584, 1, 1'b0, none};
    dir[10] = '{FUNC_ALLOC, 0, 65536, 1'b1, '{STATUS_NO_RUN, 16'd0, 17'd61950, 17'd3586}};
    dir[11] = '{FUNC_ALLOC, 0, 131071, 1'b0, none};
    dir[12] = '{FUNC_NONE, 65535, 131071, 1'b0, none};
    dir[13] = '{FUNC_FREE, 0, 1, 1'b0, none};
    dir[14] = '{FUNC_ALLOC, 0, 1, 1'b0, none};
    dir[15] = '{FUNC_ALLOC, 0, 2, 1'b0, none};
    dir[16] = '{FUNC_FREE, 60000, 5536, 1'b0, none};
    dir[17] = '{FUNC_MARK, 0, 0, 1'b0, none};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir[i]) begin
      r.func = dir[i].f;
      r.page_index = 16'(dir[i].idx);
      r.page_count = 17'(dir[i].cnt);
      send(r, dir[i].lit, dir[i].res);
    end

    for (int i = 0; i < NRandom; i++) begin
      if (i == NRandom / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 15;
      end else if (i == 2 * NRandom / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send(random_item(), 1'b0, none);
    end
    req.valid <= 1'b0;

    while (result_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d requests: %0d allocations placed, %0d with no run, %0d range errors",
             n_sent, n_alloc_ok, n_no_run, n_range);
    $display("three idle mixes on request and response side, %0d mismatches", errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_if.sv
rtl/core/bpa_ram.sv
rtl/core/bitmap_page_allocator.sv
sim/tb_bitmap_page_allocator.sv
